// File: hdl/ssse_pkg.sv
// Shared widths, codes and sequencer states of the strided suffix-sum engine.
`default_nettype none

package ssse_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 11;
    localparam int PTR_W   = LEN_W + 1;
    localparam int SUM_W   = 43;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic MODE_ASSIGN = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } ssse_state_t;

endpackage

`default_nettype wire

// File: hdl/ssse_if.sv
// Request, response and configuration channel interfaces of the engine.
`default_nettype none

interface ssse_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  mode;
    logic        [ssse_pkg::INDEX_W-1:0]   index;
    logic signed [ssse_pkg::VALUE_W-1:0]   new_value;
    logic        [ssse_pkg::LEN_W-1:0]     stride;

    modport source (output valid, output mode, output index, output new_value,
                    output stride, input ready);
    modport sink   (input valid, input mode, input index, input new_value,
                    input stride, output ready);
endinterface

interface ssse_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ssse_pkg::SUM_W-1:0]     sum;

    modport source (output valid, output sum, input ready);
    modport sink   (input valid, input sum, output ready);
endinterface

interface ssse_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic        [ssse_pkg::LEN_W-1:0]     array_length;

    modport source (output valid, output array_length, input ready);
    modport sink   (input valid, input array_length, output ready);
endinterface

`default_nettype wire

// File: hdl/strided_suffix_sum_engine.sv
// Strided suffix-sum engine: element store, query walker and response register.
//
// Channels: req carries assign requests (mode 0: write new_value at index) and
// query requests (mode 1: sum of the elements at index, index+stride, ... below
// the configured length; stride 0 sums only the start element). rsp carries one
// 43-bit signed sum per query; assigns produce no response. cfg writes
// array_length at any time; lengths above MAX_ELEMENTS act as MAX_ELEMENTS.
// Timing: after an assign request the engine is ready again the next cycle. A
// query of k terms, k = ceil((length - index) / stride) or zero (one or zero for
// stride 0), walks through the WALK and DONE states before rsp.valid rises, and
// the next request is taken only once the engine is back in IDLE; one element
// store read port, reading one element per cycle into a single shared
// accumulator, paces the walk.
// Reset: after reset the element store is swept to zero, one entry per cycle,
// from entry 0 up to entry MAX_ELEMENTS - 1; req.ready stays low during the
// sweep, cfg writes are taken as usual.
// Stall: a finished sum sits in the response register until rsp.ready; a new
// request may be accepted meanwhile, but a second query holds in its final
// step until the response register frees up.
`default_nettype none

module strided_suffix_sum_engine #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssse_req_if.sink    req,
    ssse_rsp_if.source  rsp,
    ssse_cfg_if.sink    cfg
);

    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    ssse_pkg::ssse_state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]                      clr_ptr_reg, clr_ptr_next;
    logic [ssse_pkg::LEN_W-1:0]             len_reg;
    logic [ssse_pkg::LEN_W-1:0]             walk_len_reg, walk_len_next;
    logic [ssse_pkg::LEN_W-1:0]             stride_reg, stride_next;
    logic [ssse_pkg::PTR_W-1:0]             ptr_reg, ptr_next;
    logic                                   pend_reg, pend_next;
    logic signed [ssse_pkg::SUM_W-1:0]      acc_reg, acc_next;
    logic                                   out_valid_reg, out_valid_next;
    logic signed [ssse_pkg::SUM_W-1:0]      out_sum_reg, out_sum_next;

    logic [ssse_pkg::LEN_W-1:0]             len_eff;
    logic                                   issue;
    logic                                   req_ready;
    logic                                   ram_we;
    logic [ADDR_W-1:0]                      ram_waddr;
    logic [ssse_pkg::VALUE_W-1:0]           ram_wdata;
    logic [ADDR_W-1:0]                      ram_raddr;
    logic [ssse_pkg::VALUE_W-1:0]           ram_rdata;

    // Element store; one write port for sweep and assigns, one read port for walks.
    ssse_ram #(
        .WIDTH (ssse_pkg::VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clip the configured length to the store capacity.
    assign len_eff = ({21'b0, len_reg} > 32'(MAX_ELEMENTS))
                   ? ssse_pkg::LEN_W'(MAX_ELEMENTS) : len_reg;

    // A read goes out while the walk pointer is still inside the array.
    assign issue     = (ptr_reg < {1'b0, walk_len_reg});
    assign ram_raddr = ADDR_W'(ptr_reg);

    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.sum   = out_sum_reg;

    // Configuration register: take a request whenever it arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= ssse_pkg::LEN_RESET;
        end
        else if (cfg.valid)
        begin
            len_reg <= cfg.array_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssse_pkg::ST_CLEAR;
            clr_ptr_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        walk_len_reg <= walk_len_next;
        stride_reg   <= stride_next;
        ptr_reg      <= ptr_next;
        acc_reg      <= acc_next;
        out_sum_reg  <= out_sum_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        walk_len_next  = walk_len_reg;
        stride_next    = stride_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        acc_next       = acc_reg;
        out_sum_next   = out_sum_reg;
        // Drop the response once the receiver takes it.
        out_valid_next = out_valid_reg && !rsp.ready;
        req_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_ptr_reg;
        ram_wdata      = '0;

        unique case (state_reg)
            ssse_pkg::ST_CLEAR:
            begin
                // Sweep zeros through the store, one entry per cycle.
                ram_we       = 1'b1;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == ADDR_W'(MAX_ELEMENTS - 1))
                begin
                    state_next = ssse_pkg::ST_IDLE;
                end
            end

            ssse_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    if (req.mode == ssse_pkg::MODE_ASSIGN)
                    begin
                        // Indexes beyond the store capacity are dropped.
                        ram_we    = ({22'b0, req.index} < 32'(MAX_ELEMENTS));
                        ram_waddr = ADDR_W'(req.index);
                        ram_wdata = req.new_value;
                    end
                    else
                    begin
                        // Stride zero: step by the length so the walk ends after
                        // the start element.
                        ptr_next      = {2'b0, req.index};
                        walk_len_next = len_eff;
                        stride_next   = (req.stride == '0) ? len_eff : req.stride;
                        acc_next      = '0;
                        state_next    = ssse_pkg::ST_WALK;
                    end
                end
            end

            ssse_pkg::ST_WALK:
            begin
                pend_next = issue;
                if (issue)
                begin
                    ptr_next = ptr_reg + {1'b0, stride_reg};
                end
                // Add the element read out in the previous cycle.
                if (pend_reg)
                begin
                    acc_next = acc_reg + {{(ssse_pkg::SUM_W - ssse_pkg::VALUE_W)
                                          {ram_rdata[ssse_pkg::VALUE_W-1]}}, ram_rdata};
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ssse_pkg::ST_DONE;
                end
            end

            ssse_pkg::ST_DONE:
            begin
                // Hold the sum until the response register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    state_next     = ssse_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ssse_pkg::ST_IDLE;
            end
        endcase
    end

    // The store is never written while a walk reads it.
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssse_pkg::ST_WALK) |-> !ram_we)
        else $error("store written during a query walk");

    // Each issued read advances the pointer by exactly one stride.
    a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssse_pkg::ST_WALK && issue) |=>
        (ptr_reg == $past(ptr_reg) + {1'b0, $past(stride_reg)}))
        else $error("walk pointer skipped a stride");

    // A response appears only out of the final query step.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ssse_pkg::ST_DONE))
        else $error("response raised outside the final step");

    // An accepted query starts a walk from a cleared accumulator.
    a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req_ready && req.mode == ssse_pkg::MODE_QUERY) |=>
        (state_reg == ssse_pkg::ST_WALK && acc_reg == '0 && !req_ready))
        else $error("query did not start a clean walk");

endmodule

`default_nettype wire

// File: hdl/ssse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output      logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
